### rtl/egbm_pkg.sv
// ----------------------------------------------------------------------------
// egbm_pkg
// shared types, widths and constants of the gbm path stepper
// ----------------------------------------------------------------------------
package egbm_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_VALUE     = 3'd0,
        CFG_STRIKE          = 3'd1,
        CFG_DRIFT_COEFF     = 3'd2,
        CFG_DIFFUSION_COEFF = 3'd3,
        CFG_STEPS_PER_PATH  = 3'd4
    } t_cfg_index;

    localparam logic [30:0] START_VALUE_RST    = 31'd6553600;
    localparam logic [30:0] STRIKE_RST         = 31'd6553600;
    localparam logic [15:0] STEPS_PER_PATH_RST = 16'd100;

    localparam logic signed [35:0] COEF_MAX = 36'sd4294967295;
    localparam logic signed [35:0] COEF_MIN = -36'sd4294967295;
    localparam logic signed [47:0] COEF_HALF = 48'sd2048;
    localparam logic signed [64:0] PROD_HALF = 65'sd536870912;

    localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic [30:0] PAYOFF_MAX = 31'h7fff_ffff;
    localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;

    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic path_end;
    } t_status;

endpackage

### rtl/egbm_ctrl.sv
// ----------------------------------------------------------------------------
// egbm_ctrl
// step sequencer and output valid tracking
// ----------------------------------------------------------------------------
module egbm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  egbm_pkg::t_status i_status,
    output egbm_pkg::t_cmd   o_cmd
);
    import egbm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_slot_free;
    logic   w_proceed;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_proceed   = !i_status.path_end || w_slot_free;

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul  = (r_state == S_MUL);
        o_cmd.upd  = (r_state == S_UPD) && w_proceed;
        o_cmd.emit = (r_state == S_UPD) && w_proceed && i_status.path_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_proceed) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/egbm_dp.sv
// ----------------------------------------------------------------------------
// egbm_dp
// configuration registers, euler step arithmetic and result registers
// ----------------------------------------------------------------------------
module egbm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [egbm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [egbm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [15:0]                  i_normal_sample,
    input  egbm_pkg::t_cmd                      i_cmd,
    output egbm_pkg::t_status                   o_status,
    output logic signed [31:0]                  o_end_value,
    output logic [30:0]                         o_call_payoff,
    output logic [30:0]                         o_put_payoff,
    output logic [31:0]                         o_zero_hit_total
);
    import egbm_pkg::*;

    logic [30:0]        r_start_value;
    logic [30:0]        r_strike;
    logic signed [31:0] r_drift_coeff;
    logic [30:0]        r_diffusion_coeff;
    logic [15:0]        r_steps_per_path;

    logic signed [31:0] r_path_value;
    logic [15:0]        r_step_index;
    logic [31:0]        r_zero_hits;

    logic signed [32:0] r_coef;
    logic signed [31:0] r_v;
    logic signed [64:0] r_prod;

    logic signed [31:0] r_end_value;
    logic [30:0]        r_call_payoff;
    logic [30:0]        r_put_payoff;
    logic [31:0]        r_zero_hit_total;

    logic signed [46:0] w_ds;
    logic signed [47:0] w_sum42;
    logic signed [47:0] w_sum_rnd;
    logic signed [35:0] w_c;
    logic signed [32:0] w_c_sat;
    logic signed [31:0] w_v;

    logic signed [64:0] w_prod_rnd;
    logic signed [34:0] w_inc;
    logic signed [35:0] w_nv_wide;
    logic signed [31:0] w_nv;
    logic               w_nonpos;
    logic [15:0]        w_step_next;
    logic [15:0]        w_limit;
    logic               w_path_end;
    logic signed [32:0] w_call_d;
    logic signed [32:0] w_put_d;
    logic [30:0]        w_call;
    logic [30:0]        w_put;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_value     <= START_VALUE_RST;
            r_strike          <= STRIKE_RST;
            r_drift_coeff     <= '0;
            r_diffusion_coeff <= '0;
            r_steps_per_path  <= STEPS_PER_PATH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_VALUE:     r_start_value     <= i_cfg_data[30:0];
                CFG_STRIKE:          r_strike          <= i_cfg_data[30:0];
                CFG_DRIFT_COEFF:     r_drift_coeff     <= $signed(i_cfg_data);
                CFG_DIFFUSION_COEFF: r_diffusion_coeff <= i_cfg_data[30:0];
                CFG_STEPS_PER_PATH:  r_steps_per_path  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // coefficient in q.30, rounded and clamped
    assign w_ds      = $signed({1'b0, r_diffusion_coeff}) * i_normal_sample;
    assign w_sum42   = {{4{r_drift_coeff[31]}}, r_drift_coeff, 12'b0} + {w_ds[46], w_ds};
    assign w_sum_rnd = w_sum42 + COEF_HALF;
    assign w_c       = w_sum_rnd[47:12];

    always_comb begin
        if (w_c > COEF_MAX) begin
            w_c_sat = COEF_MAX[32:0];
        end else if (w_c < COEF_MIN) begin
            w_c_sat = COEF_MIN[32:0];
        end else begin
            w_c_sat = w_c[32:0];
        end
    end

    assign w_v = (r_step_index == '0) ? $signed({1'b0, r_start_value}) : r_path_value;

    // value update
    assign w_prod_rnd = r_prod + PROD_HALF;
    assign w_inc      = w_prod_rnd[64:30];
    assign w_nv_wide  = {{4{r_v[31]}}, r_v} + {w_inc[34], w_inc};

    always_comb begin
        if (w_nv_wide[35:31] == 5'b00000 || w_nv_wide[35:31] == 5'b11111) begin
            w_nv = w_nv_wide[31:0];
        end else if (w_nv_wide[35]) begin
            w_nv = VALUE_MIN;
        end else begin
            w_nv = VALUE_MAX;
        end
    end

    assign w_nonpos    = w_nv[31] || (w_nv == '0);
    assign w_step_next = r_step_index + 16'd1;
    assign w_limit     = (r_steps_per_path == '0) ? 16'd1 : r_steps_per_path;
    assign w_path_end  = (w_step_next == '0) || (w_step_next >= w_limit);

    // payoffs against strike
    assign w_call_d = {w_nv[31], w_nv} - $signed({2'b00, r_strike});
    assign w_put_d  = $signed({2'b00, r_strike}) - {w_nv[31], w_nv};

    always_comb begin
        if (w_call_d > 33'sd0) begin
            w_call = w_call_d[30:0];
        end else begin
            w_call = '0;
        end
        if (w_put_d <= 33'sd0) begin
            w_put = '0;
        end else if (w_put_d[31]) begin
            w_put = PAYOFF_MAX;
        end else begin
            w_put = w_put_d[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_coef <= w_c_sat;
            r_v    <= w_v;
        end
        if (i_cmd.mul) begin
            r_prod <= r_v * r_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_value <= '0;
            r_step_index <= '0;
            r_zero_hits  <= '0;
        end else if (i_cmd.upd) begin
            r_path_value <= w_nv;
            r_step_index <= w_path_end ? 16'd0 : w_step_next;
            if (w_nonpos && r_zero_hits != COUNT_MAX) begin
                r_zero_hits <= r_zero_hits + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_end_value      <= w_nv;
            r_call_payoff    <= w_call;
            r_put_payoff     <= w_put;
            r_zero_hit_total <= (w_nonpos && r_zero_hits != COUNT_MAX) ?
                                r_zero_hits + 32'd1 : r_zero_hits;
        end
    end

    assign o_status.path_end = w_path_end;
    assign o_end_value       = r_end_value;
    assign o_call_payoff     = r_call_payoff;
    assign o_put_payoff      = r_put_payoff;
    assign o_zero_hit_total  = r_zero_hit_total;

endmodule

### rtl/euler_gbm_path_step_top.sv
// ----------------------------------------------------------------------------
// euler_gbm_path_step_top
// euler-maruyama gbm path stepper with call and put payoffs at path end
// ----------------------------------------------------------------------------
// Each accepted normal sample advances the path by one Euler step: the
// coefficient is formed as the sample is taken, the value times coefficient
// product is registered in the next cycle, and the value, zero-hit count and
// step counter are then updated in the update state. The value recurrence
// through the value multiplier forces this sequence; the input is
// stalled while a step is in flight. After steps_per_path samples one result
// transaction is loaded into the output register; if the previous result is
// still held there, the final step waits until it is taken. Configuration
// writes take effect at once and start_value is used at the next path start.
module euler_gbm_path_step_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [egbm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [egbm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [15:0]                 i_normal_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [31:0]                 o_end_value,
    output logic [30:0]                        o_call_payoff,
    output logic [30:0]                        o_put_payoff,
    output logic [31:0]                        o_zero_hit_total
);
    import egbm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    egbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    egbm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_normal_sample  (i_normal_sample),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_end_value      (o_end_value),
        .o_call_payoff    (o_call_payoff),
        .o_put_payoff     (o_put_payoff),
        .o_zero_hit_total (o_zero_hit_total)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a transaction");

    a_payoff_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_call_payoff == '0 || o_put_payoff == '0))
        else $error("call and put both nonzero");

    a_negative_no_call: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_value[31]) |-> (o_call_payoff == '0))
        else $error("call payoff on negative end value");
`endif

endmodule

### verif/egbm_path_checker.sv
// ----------------------------------------------------------------------------
// egbm_path_checker
// watches the sample, result and register ports of the gbm path stepper,
// predicts every path end result and compares it field by field
// ----------------------------------------------------------------------------
module egbm_path_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [egbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [egbm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic signed [15:0]                i_normal_sample,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [31:0]                i_end_value,
    input  logic [30:0]                       i_call_payoff,
    input  logic [30:0]                       i_put_payoff,
    input  logic [31:0]                       i_zero_hit_total,
    output int unsigned                       o_fail_count,
    output int unsigned                       o_results_due
);
    import egbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COEF_CLAMP = 64'sd4294967295;
    localparam longint VAL_HI = 64'sd2147483647;
    localparam longint VAL_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] end_value;
        logic [30:0]        call_payoff;
        logic [30:0]        put_payoff;
        logic [31:0]        zero_hit_total;
    } t_path_result;

    t_path_result path_results_due[$];

    logic [30:0]        start_val;
    logic [30:0]        strike_val;
    logic signed [31:0] drift_val;
    logic [30:0]        diffusion_val;
    logic [15:0]        steps_val;

    logic signed [31:0] path_val;
    logic [15:0]        step_idx;
    logic [31:0]        zero_hits;

    int unsigned        mismatches;

    task automatic advance_path(input logic signed [15:0] sample);
        longint       v;
        longint       sum42;
        longint       coef;
        longint       nv;
        longint       k;
        longint       call_l;
        longint       put_l;
        logic [15:0]  limit;
        t_path_result res;
        v = (step_idx == 16'd0) ? longint'(start_val) : longint'(path_val);
        sum42 = longint'(drift_val) * 64'sd4096 + longint'(diffusion_val) * longint'(sample);
        coef = (sum42 + 64'sd2048) >>> 12;
        if (coef > COEF_CLAMP) coef = COEF_CLAMP;
        if (coef < -COEF_CLAMP) coef = -COEF_CLAMP;
        nv = v + ((v * coef + 64'sd536870912) >>> 30);
        if (nv > VAL_HI) nv = VAL_HI;
        if (nv < VAL_LO) nv = VAL_LO;
        path_val = nv[31:0];
        if (nv <= 0 && zero_hits != 32'hffff_ffff) zero_hits = zero_hits + 32'd1;
        limit = (steps_val == 16'd0) ? 16'd1 : steps_val;
        step_idx = step_idx + 16'd1;
        if (step_idx != 16'd0 && step_idx < limit) return;
        step_idx = 16'd0;
        k = longint'(strike_val);
        call_l = (nv > k) ? nv - k : 0;
        put_l = (k > nv) ? k - nv : 0;
        if (put_l > VAL_HI) put_l = VAL_HI;
        res.end_value = nv[31:0];
        res.call_payoff = call_l[30:0];
        res.put_payoff = put_l[30:0];
        res.zero_hit_total = zero_hits;
        path_results_due.insert(path_results_due.size(), res);
    endtask

    always @(posedge i_clk) begin
        t_path_result got;
        t_path_result want;
        if (!i_rst_n) begin
            start_val = START_VALUE_RST;
            strike_val = STRIKE_RST;
            drift_val = '0;
            diffusion_val = '0;
            steps_val = STEPS_PER_PATH_RST;
            path_val = '0;
            step_idx = '0;
            zero_hits = '0;
            mismatches = 0;
            path_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_START_VALUE:     start_val = i_cfg_data[30:0];
                    CFG_STRIKE:          strike_val = i_cfg_data[30:0];
                    CFG_DRIFT_COEFF:     drift_val = i_cfg_data;
                    CFG_DIFFUSION_COEFF: diffusion_val = i_cfg_data[30:0];
                    CFG_STEPS_PER_PATH:  steps_val = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.end_value = i_end_value;
                got.call_payoff = i_call_payoff;
                got.put_payoff = i_put_payoff;
                got.zero_hit_total = i_zero_hit_total;
                if (path_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: end=%0d call=%0d put=%0d hits=%0d",
                                 got.end_value, got.call_payoff, got.put_payoff,
                                 got.zero_hit_total);
                end else begin
                    want = path_results_due.pop_front();
                    if (want != got) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: expected end=%0d call=%0d put=%0d hits=%0d",
                                     want.end_value, want.call_payoff, want.put_payoff,
                                     want.zero_hit_total);
                            $display("                 actual   end=%0d call=%0d put=%0d hits=%0d",
                                     got.end_value, got.call_payoff, got.put_payoff,
                                     got.zero_hit_total);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) advance_path(i_normal_sample);
        end
        o_fail_count <= mismatches;
        o_results_due <= path_results_due.size();
    end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives normal samples and register writes into the gbm path stepper under
// several idling patterns and gives the verdict from the checker's count
// ----------------------------------------------------------------------------
module testbench;
    import egbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 128;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic signed [15:0]     normal_sample = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [31:0]     end_value;
    logic [30:0]            call_payoff;
    logic [30:0]            put_payoff;
    logic [31:0]            zero_hit_total;

    int unsigned            fail_count;
    int unsigned            results_due;
    int                     tx_idle_pct = 0;
    int                     rx_idle_pct = 0;
    int                     cycle_count = 0;

    always #2 clk = ~clk;

    euler_gbm_path_step_top i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_normal_sample  (normal_sample),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_end_value      (end_value),
        .o_call_payoff    (call_payoff),
        .o_put_payoff     (put_payoff),
        .o_zero_hit_total (zero_hit_total)
    );

    egbm_path_checker i_path_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_normal_sample  (normal_sample),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_end_value      (end_value),
        .i_call_payoff    (call_payoff),
        .i_put_payoff     (put_payoff),
        .i_zero_hit_total (zero_hit_total),
        .o_fail_count     (fail_count),
        .o_results_due    (results_due)
    );

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("euler_gbm_path_step_top test failed");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [15:0] value);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        normal_sample <= value;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] start_v, input logic [31:0] strike_v,
                              input logic [31:0] drift_v, input logic [31:0] diff_v,
                              input logic [31:0] steps_v);
        write_reg(CFG_START_VALUE, start_v);
        write_reg(CFG_STRIKE, strike_v);
        write_reg(CFG_DRIFT_COEFF, drift_v);
        write_reg(CFG_DIFFUSION_COEFF, diff_v);
        write_reg(CFG_STEPS_PER_PATH, steps_v);
    endtask

    // sender holds off until every path end result has been taken
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [15:0] random_sample();
        int roll;
        int acc;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            acc = $urandom;
            return acc[15:0];
        end
        if (roll == 1) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        acc = $urandom_range(0, 8192) + $urandom_range(0, 8192) + $urandom_range(0, 8192);
        acc = acc - 12288;
        return acc[15:0];
    endfunction

    initial begin
        logic [31:0] start_v;
        logic [31:0] strike_v;
        logic [31:0] drift_v;
        logic [31:0] diff_v;
        logic [31:0] steps_v;
        int          roll;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        // neutral coefficients, one step per path
        set_config(32'd6553600, 32'd6553600, 32'd0, 32'd0, 32'd1);
        send_sample(16'sd0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        wait_drained();

        // coefficient and value saturation, put overflow against zero strike
        set_config(32'h7fff_ffff, 32'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        wait_drained();

        // zero start value, most negative drift, step count of zero
        set_config(32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd0);
        send_sample(16'sh5555);
        send_sample(16'shaaaa);
        wait_drained();

        // new start value takes effect at the next path start
        set_config(32'd6553600, 32'd6553600, 32'h0010_0000, 32'h0100_0000, 32'd3);
        send_sample(16'sd4096);
        send_sample(-16'sd4096);
        send_sample(16'sd1000);
        wait_drained();
        write_reg(CFG_START_VALUE, 32'd13107200);
        send_sample(16'sd2048);
        send_sample(-16'sd300);
        send_sample(16'sd7000);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        wait_drained();
        // step count lowered below the steps already taken
        write_reg(CFG_STEPS_PER_PATH, 32'd1);
        send_sample(16'sd1234);
        wait_drained();

        // longest path, then cut short
        write_reg(CFG_STEPS_PER_PATH, 32'd65535);
        send_sample(-16'sd5000);
        send_sample(16'sd5000);
        wait_drained();
        write_reg(CFG_STEPS_PER_PATH, 32'd2);
        send_sample(16'sd0);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                1: begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 85;
                end
                default: begin
                    tx_idle_pct = 14;
                    rx_idle_pct = 14;
                end
            endcase

            roll = $urandom_range(0, 5);
            if (roll == 0) start_v = 32'd0;
            else if (roll == 1) start_v = 32'h7fff_ffff;
            else if (roll == 2) start_v = $urandom & 32'h7fff_ffff;
            else start_v = $urandom_range(32'h0010_0000, 32'h0100_0000);

            roll = $urandom_range(0, 5);
            if (roll == 0) strike_v = 32'd0;
            else if (roll == 1) strike_v = 32'h7fff_ffff;
            else if (roll == 2) strike_v = $urandom & 32'h7fff_ffff;
            else strike_v = $urandom_range(32'h0010_0000, 32'h0100_0000);

            roll = $urandom_range(0, 5);
            if (roll == 0) drift_v = 32'h8000_0000;
            else if (roll == 1) drift_v = 32'h7fff_ffff;
            else if (roll == 2) drift_v = $urandom;
            else drift_v = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;

            roll = $urandom_range(0, 5);
            if (roll == 0) diff_v = 32'd0;
            else if (roll == 1) diff_v = 32'h7fff_ffff;
            else if (roll == 2) diff_v = $urandom & 32'h7fff_ffff;
            else diff_v = $urandom_range(0, 32'h0400_0000);

            roll = $urandom_range(0, 5);
            if (roll == 0) steps_v = 32'd0;
            else if (roll == 1) steps_v = $urandom_range(20, 40);
            else steps_v = $urandom_range(1, 8);

            set_config(start_v, strike_v, drift_v, diff_v, steps_v);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_sample(random_sample());
            end
            wait_drained();
        end

        if (fail_count == 0 && results_due == 0) begin
            $display("euler_gbm_path_step_top test passed");
        end else begin
            $display("euler_gbm_path_step_top test failed");
        end
        $finish;
    end

endmodule
